// File: hw/rtl/jvsl_pkg.sv
// Shared types, widths and constants of the joystick velocity slew limiter.
// Depends on nothing; every other module of the block imports it.
`timescale 1ns / 1ps
package jvsl_pkg;

	// Sample grouping and converter resolution. SAMPLE_COUNT must be a power of two.
	localparam int SAMPLE_COUNT = 32;
	localparam int ADC_BITS     = 12;
	localparam int ADC_MID      = (2 ** ADC_BITS - 1) / 2;

	// Fixed field widths.
	localparam int SAMPLE_W   = 12;
	localparam int DB_W       = 11;
	localparam int SPEED_W    = 15;
	localparam int SSPEED_W   = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;

	// Derived widths.
	localparam int AVG_SHIFT = $clog2(SAMPLE_COUNT);
	localparam int IDX_W     = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
	localparam int SUM_W     = ADC_BITS + AVG_SHIFT;
	localparam int MOT_W     = ADC_BITS - 1;
	localparam int PROD_W    = ADC_BITS + SPEED_W;
	localparam int DCNT_W    = $clog2(PROD_W);
	localparam int EXT_W     = 17;
	localparam int SLEW_W    = SSPEED_W + 2;

	// Queue between the front and back parts.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_DEADBAND  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SLEW_STEP = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FLIP_DIR  = 3'd4;

	// Deflection zones decided by the front part.
	localparam logic [1:0] ZONE_STOP  = 2'd0;
	localparam logic [1:0] ZONE_FULL  = 2'd1;
	localparam logic [1:0] ZONE_SCALE = 2'd2;

	typedef struct packed {
		logic [DB_W-1:0]    deadband;
		logic [SPEED_W-1:0] min_speed;
		logic [SPEED_W-1:0] max_speed;
		logic [SPEED_W-1:0] slew_step;
		logic               flip_direction;
	} cfg_t;

	// One classified group average.
	typedef struct packed {
		logic                neg;
		logic [1:0]          zone;
		logic [ADC_BITS-1:0] excess;
	} entry_t;

	typedef struct packed {
		logic                       direction;
		logic                       pulse_enable;
		logic [SPEED_W-1:0]         step_frequency;
		logic signed [SSPEED_W-1:0] signed_speed;
	} res_t;

	// Keeps the converter bits of a raw sample.
	function automatic logic [ADC_BITS-1:0] adc_mask(input logic [SAMPLE_W-1:0] s);
		logic [15:0] wide;
		wide = 16'(s);
		return wide[ADC_BITS-1:0];
	endfunction

endpackage

// File: hw/rtl/jvsl_front.sv
// Front part: sums samples, forms the group average and classifies its deflection.
// Depends on jvsl_pkg; feeds jvsl_queue.
`timescale 1ns / 1ps
module jvsl_front import jvsl_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  logic                push,
	output logic                full,
	input  logic [SAMPLE_W-1:0] sample,
	input  logic [QCNT_W-1:0]   q_count,
	output logic                q_push,
	output entry_t              q_entry
);

	logic [SUM_W-1:0]    sum_q;
	logic [IDX_W-1:0]    idx_q;
	logic [SUM_W-1:0]    total;
	logic                accept;
	logic                last;
	logic                valid_s1;
	logic [ADC_BITS-1:0] avg_s1;
	logic [QCNT_W:0]     used;
	logic                below;
	logic [ADC_BITS-1:0] mag;
	logic [EXT_W-1:0]    mag_ext;
	logic [EXT_W-1:0]    db_ext;
	logic [EXT_W-1:0]    diff;

	// A slot in the queue is reserved for an average still in stage one.
	assign used   = (QCNT_W + 1)'(q_count) + (QCNT_W + 1)'(valid_s1);
	assign full   = used >= (QCNT_W + 1)'(QUEUE_DEPTH);
	assign accept = push && !full;
	assign last   = idx_q == IDX_W'(SAMPLE_COUNT - 1);
	assign total  = sum_q + SUM_W'(adc_mask(sample));

	// Accumulate the group and register its average on the last beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			idx_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept && last;
			if (accept) begin
				if (last) begin
					sum_q <= '0;
					idx_q <= '0;
				end else begin
					sum_q <= total;
					idx_q <= idx_q + IDX_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last) begin
			avg_s1 <= total[SUM_W-1:AVG_SHIFT];
		end
	end

	// Centre the average and sort it into stop, full-scale or scaled zones.
	always_comb begin
		below   = avg_s1 < ADC_BITS'(ADC_MID);
		mag     = below ? ADC_BITS'(ADC_MID) - avg_s1 : avg_s1 - ADC_BITS'(ADC_MID);
		mag_ext = EXT_W'(mag);
		db_ext  = EXT_W'(cfg.deadband);
		diff    = mag_ext - db_ext;
		q_entry.neg    = below;
		q_entry.excess = diff[ADC_BITS-1:0];
		if (mag_ext < db_ext) begin
			q_entry.zone = ZONE_STOP;
		end else if (db_ext >= EXT_W'(ADC_MID)) begin
			q_entry.zone = ZONE_FULL;
		end else begin
			q_entry.zone = ZONE_SCALE;
		end
	end

	assign q_push = valid_s1;

endmodule

// File: hw/rtl/jvsl_queue.sv
// Short queue of classified averages between the front and back parts.
// Depends on jvsl_pkg.
`timescale 1ns / 1ps
module jvsl_queue import jvsl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  entry_t            wr_entry,
	input  logic              pop,
	output entry_t            rd_entry,
	output logic              empty,
	output logic [QCNT_W-1:0] count
);

	entry_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_pop;

	assign empty    = count_q == '0;
	assign count    = count_q;
	assign do_pop   = pop && !empty;
	assign rd_entry = mem_q[rd_ptr_q];

	// Pointers and fill count; the front never pushes into a full queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (!push && do_pop) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

endmodule

// File: hw/rtl/jvsl_back.sv
// Back part: scales the deflection to a target speed with a bit-serial divider,
// applies the slew limit and holds the result beat. Depends on jvsl_pkg.
`timescale 1ns / 1ps
module jvsl_back import jvsl_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  logic   q_empty,
	input  entry_t q_entry,
	output logic   q_pop,
	input  logic   pop,
	output logic   empty,
	output res_t   res
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL   = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_CLAMP = 3'd3;
	localparam logic [2:0] ST_SLEW  = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	logic [2:0]                 state_q;
	logic                       neg_q;
	logic [ADC_BITS-1:0]        excess_q;
	logic [SPEED_W-1:0]         tgt_mag_q;
	logic [PROD_W-1:0]          div_q;
	logic [MOT_W-1:0]           rem_q;
	logic [DCNT_W-1:0]          cnt_q;
	logic signed [SSPEED_W-1:0] cur_q;
	logic                       out_valid_q;
	res_t                       res_q;

	logic [SPEED_W-1:0]         span;
	logic [SPEED_W-1:0]         top;
	logic [EXT_W-1:0]           motion_ext;
	logic [MOT_W-1:0]           motion;
	logic [MOT_W:0]             trial;
	logic                       fits;
	logic [MOT_W:0]             trial_left;
	logic signed [SLEW_W-1:0]   tgt_ext;
	logic signed [SLEW_W-1:0]   cur_ext;
	logic signed [SLEW_W-1:0]   step_ext;
	logic signed [SLEW_W-1:0]   up;
	logic signed [SLEW_W-1:0]   dn;
	logic signed [SLEW_W-1:0]   next_ext;
	logic [SSPEED_W-1:0]        abs_cur;
	logic [SPEED_W-1:0]         cur_mag;
	logic                       en;
	logic                       out_load;

	// Speed range and divisor follow registers; user must hold them still while busy.
	assign span       = (cfg.max_speed >= cfg.min_speed) ? cfg.max_speed - cfg.min_speed : '0;
	assign top        = (cfg.max_speed >= cfg.min_speed) ? cfg.max_speed : cfg.min_speed;
	assign motion_ext = EXT_W'(ADC_MID) - EXT_W'(cfg.deadband);
	assign motion     = motion_ext[MOT_W-1:0];

	// One restoring division step: shift in the next dividend bit, subtract if it fits.
	assign trial      = {rem_q, div_q[PROD_W-1]};
	assign fits       = trial >= {1'b0, motion};
	assign trial_left = trial - {1'b0, motion};

	// Slew limit toward the target.
	always_comb begin
		tgt_ext  = neg_q ? -SLEW_W'(signed'({1'b0, tgt_mag_q})) : SLEW_W'(signed'({1'b0, tgt_mag_q}));
		cur_ext  = SLEW_W'(cur_q);
		step_ext = SLEW_W'(signed'({1'b0, cfg.slew_step}));
		up       = cur_ext + step_ext;
		dn       = cur_ext - step_ext;
		if (tgt_ext > up) begin
			next_ext = up;
		end else if (tgt_ext < dn) begin
			next_ext = dn;
		end else begin
			next_ext = tgt_ext;
		end
	end

	// Result fields from the current speed.
	assign abs_cur  = cur_q[SSPEED_W-1] ? SSPEED_W'(-cur_q) : SSPEED_W'(cur_q);
	assign cur_mag  = abs_cur[SPEED_W-1:0];
	assign en       = cur_mag >= cfg.min_speed;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || pop);
	assign q_pop    = (state_q == ST_IDLE) && !q_empty;

	// Sequencer for one group average.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						case (q_entry.zone)
							ZONE_STOP:  state_q <= ST_SLEW;
							ZONE_FULL:  state_q <= ST_SLEW;
							default:    state_q <= ST_MUL;
						endcase
					end
				end
				ST_MUL: state_q <= ST_DIV;
				ST_DIV: begin
					if (cnt_q == DCNT_W'(PROD_W - 1)) begin
						state_q <= ST_CLAMP;
					end
				end
				ST_CLAMP: state_q <= ST_SLEW;
				ST_SLEW: begin
					cur_q   <= next_ext[SSPEED_W-1:0];
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers of the sequencer.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					neg_q    <= q_entry.neg;
					excess_q <= q_entry.excess;
					case (q_entry.zone)
						ZONE_STOP: tgt_mag_q <= '0;
						ZONE_FULL: tgt_mag_q <= top;
						default:   tgt_mag_q <= tgt_mag_q;
					endcase
				end
			end
			ST_MUL: begin
				div_q <= PROD_W'(excess_q) * PROD_W'(span);
				rem_q <= '0;
				cnt_q <= '0;
			end
			ST_DIV: begin
				div_q <= {div_q[PROD_W-2:0], fits};
				rem_q <= fits ? trial_left[MOT_W-1:0] : trial[MOT_W-1:0];
				cnt_q <= cnt_q + DCNT_W'(1);
			end
			ST_CLAMP: begin
				// The top code lies one count past the scale; cap it at full speed.
				if (div_q > PROD_W'(span)) begin
					tgt_mag_q <= top;
				end else begin
					tgt_mag_q <= cfg.min_speed + div_q[SPEED_W-1:0];
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			res_q.direction      <= ((!cur_q[SSPEED_W-1]) && (cur_q != '0)) ^ cfg.flip_direction;
			res_q.pulse_enable   <= en;
			res_q.step_frequency <= en ? cur_mag : '0;
			res_q.signed_speed   <= cur_q;
		end
	end

	assign empty = !out_valid_q;
	assign res   = res_q;

endmodule

// File: hw/rtl/joystick_velocity_slew_limiter.sv
// Joystick velocity slew limiter: one result beat per group of SAMPLE_COUNT samples.
// Throughput: one sample per cycle while full is low. A scaled group passes through the
// multiply, the bit-serial divide, the clamp and the slew step; a group inside the
// deadband or at full scale goes straight from the queue to the slew step.
// Reset (arst_n low, asynchronous): registers return to their defaults, the sample sum,
// group count and current speed clear, and the queue and result slot empty.
`timescale 1ns / 1ps
module joystick_velocity_slew_limiter import jvsl_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic [SAMPLE_W-1:0]        sample,
	output logic                       empty,
	input  logic                       pop,
	output logic                       direction,
	output logic                       pulse_enable,
	output logic [SPEED_W-1:0]         step_frequency,
	output logic signed [SSPEED_W-1:0] signed_speed,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data
);

	cfg_t              cfg_q;
	logic              q_push;
	logic              q_pop;
	logic              q_empty;
	logic [QCNT_W-1:0] q_count;
	entry_t            wr_entry;
	entry_t            rd_entry;
	res_t              res;

	// Configuration registers; writes beyond the list are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.deadband       <= DB_W'(100);
			cfg_q.min_speed      <= SPEED_W'(32);
			cfg_q.max_speed      <= SPEED_W'(19000);
			cfg_q.slew_step      <= SPEED_W'(2000);
			cfg_q.flip_direction <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DEADBAND:  cfg_q.deadband       <= cfg_data[DB_W-1:0];
				REG_MIN_SPEED: cfg_q.min_speed      <= cfg_data[SPEED_W-1:0];
				REG_MAX_SPEED: cfg_q.max_speed      <= cfg_data[SPEED_W-1:0];
				REG_SLEW_STEP: cfg_q.slew_step      <= cfg_data[SPEED_W-1:0];
				REG_FLIP_DIR:  cfg_q.flip_direction <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	jvsl_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.push    (push),
		.full    (full),
		.sample  (sample),
		.q_count (q_count),
		.q_push  (q_push),
		.q_entry (wr_entry)
	);

	jvsl_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (wr_entry),
		.pop      (q_pop),
		.rd_entry (rd_entry),
		.empty    (q_empty),
		.count    (q_count)
	);

	jvsl_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_empty (q_empty),
		.q_entry (rd_entry),
		.q_pop   (q_pop),
		.pop     (pop),
		.empty   (empty),
		.res     (res)
	);

	assign direction      = res.direction;
	assign pulse_enable   = res.pulse_enable;
	assign step_frequency = res.step_frequency;
	assign signed_speed   = res.signed_speed;

endmodule

// File: hw/rtl/jvsl_checker.sv
// Port-level checks on the result side of the slew limiter, bound to the top level.
// Depends on jvsl_pkg and joystick_velocity_slew_limiter.
`timescale 1ns / 1ps
module jvsl_checker import jvsl_pkg::*; (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       empty,
	input logic                       pop,
	input logic                       pulse_enable,
	input logic [SPEED_W-1:0]         step_frequency,
	input logic signed [SSPEED_W-1:0] signed_speed
);

	// No result can be waiting in the first cycle out of reset.
	a_empty_after_reset: assert property (@(posedge clk) $rose(arst_n) |-> empty)
		else $error("result shown right after reset");

	// A stopped pulse train reports zero frequency.
	a_off_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pulse_enable) |-> (step_frequency == '0))
		else $error("frequency nonzero while pulses are off");

	// An enabled frequency is the magnitude of the signed speed.
	a_freq_is_mag: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pulse_enable) |->
		(SSPEED_W'(step_frequency) == (signed_speed[SSPEED_W-1] ? -signed_speed : signed_speed)))
		else $error("frequency does not match speed magnitude");

	// A result beat that is not taken holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(signed_speed) && $stable(pulse_enable)))
		else $error("waiting result changed");

endmodule

bind joystick_velocity_slew_limiter jvsl_checker u_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.empty          (empty),
	.pop            (pop),
	.pulse_enable   (pulse_enable),
	.step_frequency (step_frequency),
	.signed_speed   (signed_speed)
);

// File: tb/tb_joystick_velocity_slew_limiter.sv
// Self-checking testbench for the joystick velocity slew limiter.
// Depends on jvsl_pkg and joystick_velocity_slew_limiter; a local speed predictor
// scores every result beat against what the accepted samples should produce.
`timescale 1ns / 1ps
module tb_joystick_velocity_slew_limiter;
	import jvsl_pkg::*;

	localparam int SAMPLE_TOP   = (1 << SAMPLE_W) - 1;
	localparam int LONG_HOLD    = 800;
	localparam int DRAIN_CYCLES = 50;
	// Index with no register behind it; writes there must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       push;
	logic                       full;
	logic [SAMPLE_W-1:0]        sample;
	logic                       empty;
	logic                       pop;
	logic                       direction;
	logic                       pulse_enable;
	logic [SPEED_W-1:0]         step_frequency;
	logic signed [SSPEED_W-1:0] signed_speed;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [CFG_DATA_W-1:0]      cfg_data;

	// Predictor copy of the limiter settings, at their reset values.
	int lim_db   = 100;
	int lim_lo   = 32;
	int lim_hi   = 19000;
	int lim_slew = 2000;
	bit lim_flip = 1'b0;

	// Predictor copy of the datapath state.
	int sum_acc    = 0;
	int group_fill = 0;
	int speed      = 0;

	res_t expected_q[$];
	int   errors = 0;

	// Handshake shaping shared by the sender, the receiver and the tests.
	bit steady       = 1'b0;
	bit hold_results = 1'b0;

	joystick_velocity_slew_limiter dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.sample(sample),
		.empty(empty),
		.pop(pop),
		.direction(direction),
		.pulse_enable(pulse_enable),
		.step_frequency(step_frequency),
		.signed_speed(signed_speed),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// Adds one sample to the group; on the last sample of a group it moves the speed
	// toward the new target and returns the result beat that the block should emit.
	function automatic bit advance_speed(input logic [SAMPLE_W-1:0] s, output res_t r);
		int centred, mag, span, top, tgt, spd_mag;
		r = '0;
		sum_acc += int'(s) & ((1 << ADC_BITS) - 1);
		group_fill++;
		if (group_fill < SAMPLE_COUNT) return 1'b0;
		centred = sum_acc / SAMPLE_COUNT - ADC_MID;
		sum_acc = 0;
		group_fill = 0;
		mag = (centred < 0) ? -centred : centred;
		span = (lim_hi >= lim_lo) ? lim_hi - lim_lo : 0;
		top = lim_lo + span;
		if (mag < lim_db) begin
			tgt = 0;
		end else if (ADC_MID - lim_db <= 0) begin
			// No room left outside the deadband: any deflection is full scale.
			tgt = top;
		end else begin
			tgt = lim_lo + (mag - lim_db) * span / (ADC_MID - lim_db);
			if (tgt > top) tgt = top;
		end
		if (centred < 0) tgt = -tgt;
		// Slew limit toward the target.
		if (tgt > speed + lim_slew) speed += lim_slew;
		else if (tgt < speed - lim_slew) speed -= lim_slew;
		else speed = tgt;
		spd_mag = (speed < 0) ? -speed : speed;
		r.direction = (speed > 0) ^ lim_flip;
		r.pulse_enable = (spd_mag >= lim_lo);
		r.step_frequency = r.pulse_enable ? SPEED_W'(spd_mag) : '0;
		r.signed_speed = SSPEED_W'(speed);
		return 1'b1;
	endfunction

	function automatic void note_mismatch(input string field, input int want, input int got);
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		errors++;
	endfunction

	// Scoreboard: tracks register writes and samples, and scores every result beat.
	always @(posedge clk) begin : scoreboard
		res_t fresh, want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DEADBAND:  lim_db = int'(cfg_data[DB_W-1:0]);
					REG_MIN_SPEED: lim_lo = int'(cfg_data);
					REG_MAX_SPEED: lim_hi = int'(cfg_data);
					REG_SLEW_STEP: lim_slew = int'(cfg_data);
					REG_FLIP_DIR:  lim_flip = cfg_data[0];
					default: ;
				endcase
			end
			if (push && !full) begin
				if (advance_speed(sample, fresh)) expected_q.push_back(fresh);
			end
			if (pop && !empty) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result beat, expected none, actual speed %0d",
						$time, signed_speed);
					errors++;
				end else begin
					want = expected_q.pop_front();
					if (direction !== want.direction)
						note_mismatch("direction", want.direction, direction);
					if (pulse_enable !== want.pulse_enable)
						note_mismatch("pulse_enable", want.pulse_enable, pulse_enable);
					if (step_frequency !== want.step_frequency)
						note_mismatch("step_frequency", want.step_frequency, step_frequency);
					if (signed_speed !== want.signed_speed)
						note_mismatch("signed_speed", want.signed_speed, signed_speed);
				end
			end
		end
	end

	// Receiver: pops with random stall bursts, plus one long hold-off on request.
	initial begin : receiver
		int stall_left;
		stall_left = 0;
		pop <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				pop <= 1'b0;
				stall_left--;
			end else if (hold_results) begin
				pop <= 1'b0;
				stall_left = LONG_HOLD - 1;
				hold_results = 1'b0;
			end else if (!steady && $urandom_range(0, 9) == 0) begin
				pop <= 1'b0;
				stall_left = $urandom_range(0, 14);
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Offers one sample beat, sometimes after an idle burst, and waits until it is taken.
	task automatic send_sample(input int value);
		if (!steady && $urandom_range(0, 7) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		push <= 1'b1;
		sample <= SAMPLE_W'(value);
		do @(posedge clk); while (full);
	endtask

	// One full group around a level; a spread of 2048 or more gives uniform noise.
	task automatic send_group(input int level, input int spread);
		int s;
		repeat (SAMPLE_COUNT) begin
			if (spread >= 2048) begin
				s = int'($urandom_range(0, SAMPLE_TOP));
			end else begin
				s = level + int'($urandom_range(0, 2 * spread)) - spread;
				if (s < 0) s = 0;
				if (s > SAMPLE_TOP) s = SAMPLE_TOP;
			end
			send_sample(s);
		end
	endtask

	// Stops offering samples and waits until the block has nothing left in flight.
	// The first edge lets the scoreboard log the last accepted sample before the count
	// of outstanding results is read.
	task automatic settle();
		push <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes every register, then the spare index with junk. Only called while idle.
	task automatic program_limits(input int db, input int lo, input int hi, input int slew,
			input int flip);
		logic [CFG_IDX_W-1:0] regs [6];
		int vals [6];
		regs = '{REG_DEADBAND, REG_MIN_SPEED, REG_MAX_SPEED, REG_SLEW_STEP, REG_FLIP_DIR,
			REG_SPARE};
		vals = '{db, lo, hi, slew, flip, int'($urandom_range(0, 32767))};
		foreach (regs[i]) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= CFG_DATA_W'(vals[i]);
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	// Reset settings: centre, full negative, clamped full positive, and both sides of
	// the deadband edge.
	task automatic test_reset_defaults();
		send_group(ADC_MID, 0);
		repeat (3) send_group(0, 0);
		repeat (2) send_group(SAMPLE_TOP, 0);
		send_group(ADC_MID + 100, 0);
		send_group(ADC_MID + 99, 0);
		settle();
	endtask

	// Maximum speed below minimum speed: every deflection past the deadband maps to the minimum speed.
	task automatic test_zero_span();
		program_limits(300, 5000, 1000, 32767, 1);
		send_group(SAMPLE_TOP, 0);
		send_group(0, 0);
		send_group(ADC_MID + 300, 0);
		send_group(1500, 0);
		settle();
	endtask

	// Deadband at the midpoint leaves no scaling range; just under it leaves a range of one count.
	task automatic test_no_motion_range();
		program_limits(2047, 32, 32767, 32767, 0);
		send_group(0, 0);
		send_group(SAMPLE_TOP, 0);
		send_group(ADC_MID - 1, 0);
		settle();
		program_limits(2046, 100, 20000, 32767, 1);
		send_group(0, 0);
		send_group(SAMPLE_TOP, 0);
		send_group(ADC_MID, 0);
		settle();
	endtask

	// Register extremes: zero slew freezes the speed, zero deadband and zero minimum, and minimum equal to maximum.
	task automatic test_field_extremes();
		program_limits(0, 0, 32767, 0, 1);
		send_group(SAMPLE_TOP, 0);
		settle();
		program_limits(0, 0, 32767, 32767, 1);
		send_group(ADC_MID, 0);
		send_group(SAMPLE_TOP, 0);
		send_group(0, 0);
		send_group(ADC_MID + 1, 0);
		settle();
		program_limits(10, 32767, 32767, 1000, 0);
		send_group(SAMPLE_TOP, 0);
		settle();
	endtask

	// The receiver holds off long enough for the block to fill and stall its input
	// while samples keep coming; then the sender waits for every result.
	task automatic test_backpressure();
		steady = 1'b1;
		hold_results = 1'b1;
		repeat (5) send_group(int'($urandom_range(0, SAMPLE_TOP)), 200);
		steady = 1'b0;
		settle();
	endtask

	// Random settings per phase and well-formed groups around chosen levels, with
	// some noise groups mixed in.
	task automatic test_random_settings(input int phases, input int groups);
		int lo, level, spread;
		repeat (phases) begin
			lo = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767) : $urandom_range(32, 3000);
			program_limits(
				($urandom_range(0, 4) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 400),
				lo,
				($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767) : $urandom_range(lo, 32767),
				($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767) : $urandom_range(50, 5000),
				$urandom_range(0, 1));
			repeat (groups) begin
				spread = int'($urandom_range(0, 300));
				case ($urandom_range(0, 4))
					0: level = int'($urandom_range(0, SAMPLE_TOP));
					1: begin
						level = ADC_MID + lim_db + int'($urandom_range(0, 6)) - 3;
						spread = 0;
					end
					2: begin
						level = ADC_MID - lim_db - int'($urandom_range(0, 6)) + 3;
						spread = 0;
					end
					3: level = $urandom_range(0, 1) ? SAMPLE_TOP : 0;
					default: begin
						level = 0;
						spread = 4096;
					end
				endcase
				send_group(level, spread);
			end
			settle();
		end
	endtask

	// Final stretch with both sides streaming at full rate.
	task automatic test_steady_stream();
		steady = 1'b1;
		test_random_settings(1, 4);
	endtask

	initial begin
		arst_n <= 1'b0;
		push <= 1'b0;
		sample <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_DEADBAND;
		cfg_data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_zero_span();
		test_no_motion_range();
		test_field_extremes();
		test_backpressure();
		test_random_settings(4, 4);
		test_steady_stream();

		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#5_000_000;
		$display("%0t: timeout with %0d results outstanding", $time, expected_q.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/jvsl_pkg.sv
hw/rtl/jvsl_front.sv
hw/rtl/jvsl_queue.sv
hw/rtl/jvsl_back.sv
hw/rtl/joystick_velocity_slew_limiter.sv
hw/rtl/jvsl_checker.sv
tb/tb_joystick_velocity_slew_limiter.sv
